/* rtl/quaternion_euler_stream_monitor_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the quaternion Euler stream monitor
// Property wrappers; compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_EULER_STREAM_MONITOR_UNIT_MACROS_SVH
`define QUATERNION_EULER_STREAM_MONITOR_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define QESM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define QESM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define QESM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define QESM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/qesm_pkg.sv */
// ---------------------------------------------------------------------------
// qesm_pkg
// Shared types, constants and the arctangent table of the monitor.
// ---------------------------------------------------------------------------
package qesm_pkg;

  localparam int QUAT_WIDTH_DEF      = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 7;

  localparam int MUL_STEPS    = 16;
  localparam int CORDIC_STEPS = 23;
  localparam int SQRT_STEPS   = 32;

  localparam int MAG_W  = 66;   // magnitude registers ahead of normalising
  localparam int CORD_W = 34;   // CORDIC x/y
  localparam int Z_W    = 26;   // CORDIC angle accumulator, 2^-16 degree
  localparam int ANG_W  = 25;   // unsigned angle up to 180 degree

  localparam int DEG90  = 90 * 65536;
  localparam int DEG180 = 180 * 65536;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DRAIN, S_ANG_LOAD, S_NORM, S_CORDIC, S_ANG_END,
    S_P_CHECK, S_P_NORM, S_SQRT, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    MUL_A0, MUL_A1, MUL_B0, MUL_B1, MUL_WX, MUL_YZ, MUL_WZ, MUL_XY,
    MUL_WW, MUL_XX, MUL_YY, MUL_ZZ, MUL_LL, MUL_LH, MUL_HL, MUL_HH
  } mul_op_t;

  typedef enum logic [1:0] {
    ANG_ROLL, ANG_YAW, ANG_PITCH
  } ang_sel_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    mul_op_t    mul_op;
    ang_sel_t   ang_sel;
    logic       ang_load;
    logic       norm_step;
    logic       cordic_init;
    logic       cordic_step;
    logic [4:0] iter;
    logic       ang_write;
    logic       pitch_zero;
    logic       p_norm_step;
    logic       sqrt_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic quat_zero;
    logic ab_equal;
    logic p_zero;
    logic p_normed;
    logic mag_zero;
    logic mag_in_range;
  } status_t;

  function automatic int angle_w(input int deg, input int frac);
    return $clog2((deg << frac) + 1) + 1;
  endfunction

  // atan(2^-i) in 2^-16 degree, rounded
  function automatic logic [22:0] atan_lut(input logic [4:0] i);
    logic [22:0] v;
    case (i)
      5'd0:  v = 23'd2949120;
      5'd1:  v = 23'd1740967;
      5'd2:  v = 23'd919879;
      5'd3:  v = 23'd466945;
      5'd4:  v = 23'd234379;
      5'd5:  v = 23'd117304;
      5'd6:  v = 23'd58666;
      5'd7:  v = 23'd29335;
      5'd8:  v = 23'd14668;
      5'd9:  v = 23'd7334;
      5'd10: v = 23'd3667;
      5'd11: v = 23'd1833;
      5'd12: v = 23'd917;
      5'd13: v = 23'd458;
      5'd14: v = 23'd229;
      5'd15: v = 23'd115;
      5'd16: v = 23'd57;
      5'd17: v = 23'd29;
      5'd18: v = 23'd14;
      5'd19: v = 23'd7;
      5'd20: v = 23'd4;
      5'd21: v = 23'd2;
      5'd22: v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/qesm_ctrl.sv */
// ---------------------------------------------------------------------------
// qesm_ctrl
// Sequencer: multiply schedule, angle passes, square root and output hand-off.
// ---------------------------------------------------------------------------
module qesm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  qesm_pkg::status_t status,
  output qesm_pkg::cmd_t    cmd
);
  import qesm_pkg::*;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  ang_sel_t   ang_sel, ang_sel_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ang_sel   <= ANG_ROLL;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      ang_sel   <= ang_sel_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    ang_sel_next = ang_sel;
    cmd          = '0;
    cmd.mul_op   = mul_op_t'(cnt[3:0]);
    cmd.ang_sel  = ang_sel;
    cmd.iter     = cnt;
    in_stall     = (state != S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (status.quat_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.mul_en = 1'b1;
          cnt_next   = cnt + 5'd1;
          if (cnt == 5'(MUL_STEPS - 1)) state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        ang_sel_next = ANG_ROLL;
        state_next   = S_ANG_LOAD;
      end
      S_ANG_LOAD: begin
        cmd.ang_load = 1'b1;
        state_next   = S_NORM;
      end
      S_NORM: begin
        if (status.mag_zero) begin
          state_next = S_ANG_END;
        end else if (status.mag_in_range) begin
          cmd.cordic_init = 1'b1;
          cnt_next        = '0;
          state_next      = S_CORDIC;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        cnt_next        = cnt + 5'd1;
        if (cnt == 5'(CORDIC_STEPS - 1)) state_next = S_ANG_END;
      end
      S_ANG_END: begin
        cmd.ang_write = 1'b1;
        unique case (ang_sel)
          ANG_ROLL: begin
            ang_sel_next = ANG_YAW;
            state_next   = S_ANG_LOAD;
          end
          ANG_YAW:   state_next = S_P_CHECK;
          ANG_PITCH: state_next = S_DONE;
          default:   state_next = S_DONE;
        endcase
      end
      S_P_CHECK: begin
        if (status.ab_equal) begin
          cmd.pitch_zero = 1'b1;
          state_next     = S_DONE;
        end else if (status.p_zero) begin
          ang_sel_next = ANG_PITCH;
          state_next   = S_ANG_LOAD;
        end else begin
          state_next = S_P_NORM;
        end
      end
      S_P_NORM: begin
        if (status.p_normed) begin
          cnt_next   = '0;
          state_next = S_SQRT;
        end else begin
          cmd.p_norm_step = 1'b1;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 5'd1;
        if (cnt == 5'(SQRT_STEPS - 1)) begin
          ang_sel_next = ANG_PITCH;
          state_next   = S_ANG_LOAD;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (cmd.out_load)                out_valid_next = 1'b1;
    else if (out_valid && !out_stall) out_valid_next = 1'b0;
    else                              out_valid_next = out_valid;
  end

endmodule

/* rtl/qesm_datapath.sv */
// ---------------------------------------------------------------------------
// qesm_datapath
// Shared multiplier, CORDIC vectoring unit, integer square root and stats.
// ---------------------------------------------------------------------------
module qesm_datapath #(
  parameter  int QUAT_WIDTH      = qesm_pkg::QUAT_WIDTH_DEF,
  parameter  int ANGLE_FRAC_BITS = qesm_pkg::ANGLE_FRAC_BITS_DEF,
  localparam int ROLL_W          = qesm_pkg::angle_w(180, ANGLE_FRAC_BITS),
  localparam int PITCH_W         = qesm_pkg::angle_w(90, ANGLE_FRAC_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  qesm_pkg::cmd_t               cmd,
  output qesm_pkg::status_t            status,
  input  logic signed [QUAT_WIDTH-1:0] quat_x,
  input  logic signed [QUAT_WIDTH-1:0] quat_y,
  input  logic signed [QUAT_WIDTH-1:0] quat_z,
  input  logic signed [QUAT_WIDTH-1:0] quat_w,
  input  logic [7:0]                   sequence_number,
  input  logic [31:0]                  arrival_time_us,
  output logic signed [ROLL_W-1:0]     roll_angle,
  output logic signed [PITCH_W-1:0]    pitch_angle,
  output logic signed [ROLL_W-1:0]     yaw_angle,
  output logic [31:0]                  missed_reports,
  output logic [31:0]                  largest_gap_us,
  output logic [31:0]                  reports_seen
);
  import qesm_pkg::*;

  localparam int QRED = (QUAT_WIDTH > 16) ? QUAT_WIDTH - 16 : 0;
  localparam int SH   = 16 - ANGLE_FRAC_BITS;
  localparam int HALF = 1 << (SH - 1);

  // reduced components
  logic signed [15:0] qx, qy, qz, qw;
  logic               quat_zero;

  // multiplier
  logic signed [17:0] opa, opb;
  logic signed [35:0] prod;
  mul_op_t            prod_op;
  logic               prod_vld;

  logic [33:0]        a_acc, b_acc;
  logic signed [33:0] roll_n, yaw_n;
  logic [30:0]        sq_w, sq_x, sq_y, sq_z;
  logic [63:0]        p_acc;

  logic signed [16:0] w_m_y, x_p_z, w_p_y, x_m_z;
  logic signed [32:0] roll_x, yaw_x;
  logic signed [34:0] ab_diff;

  // square root
  logic [63:0] root, bitr, sq_trial;
  logic [4:0]  k;

  // angle unit
  logic signed [MAG_W-1:0]  src_x, src_y;
  logic [MAG_W-1:0]         mag_x, mag_y, ux, uy, m;
  logic                     neg_x, neg_y, ux_zero, uy_zero;
  logic signed [CORD_W-1:0] cx, cy, dx, dy;
  logic signed [Z_W-1:0]    cz, z_step;
  logic [ANG_W-1:0]         af, a_full, a_rnd;
  logic signed [ANG_W:0]    a_signed;

  // statistics
  logic signed [ROLL_W-1:0]  last_roll, last_yaw;
  logic signed [PITCH_W-1:0] last_pitch;
  logic [31:0] report_count, previous_time, missed_total, max_gap, gap;
  logic [7:0]  previous_sequence, missed_inc;

  assign w_m_y = 17'(qw) - 17'(qy);
  assign x_p_z = 17'(qx) + 17'(qz);
  assign w_p_y = 17'(qw) + 17'(qy);
  assign x_m_z = 17'(qx) - 17'(qz);

  always_comb begin
    unique case (cmd.mul_op)
      MUL_A0: begin opa = 18'(w_m_y); opb = 18'(w_m_y); end
      MUL_A1: begin opa = 18'(x_p_z); opb = 18'(x_p_z); end
      MUL_B0: begin opa = 18'(w_p_y); opb = 18'(w_p_y); end
      MUL_B1: begin opa = 18'(x_m_z); opb = 18'(x_m_z); end
      MUL_WX: begin opa = 18'(qw); opb = 18'(qx); end
      MUL_YZ: begin opa = 18'(qy); opb = 18'(qz); end
      MUL_WZ: begin opa = 18'(qw); opb = 18'(qz); end
      MUL_XY: begin opa = 18'(qx); opb = 18'(qy); end
      MUL_WW: begin opa = 18'(qw); opb = 18'(qw); end
      MUL_XX: begin opa = 18'(qx); opb = 18'(qx); end
      MUL_YY: begin opa = 18'(qy); opb = 18'(qy); end
      MUL_ZZ: begin opa = 18'(qz); opb = 18'(qz); end
      MUL_LL: begin opa = signed'({1'b0, a_acc[16:0]});  opb = signed'({1'b0, b_acc[16:0]});  end
      MUL_LH: begin opa = signed'({1'b0, a_acc[16:0]});  opb = signed'({1'b0, b_acc[33:17]}); end
      MUL_HL: begin opa = signed'({1'b0, a_acc[33:17]}); opb = signed'({1'b0, b_acc[16:0]});  end
      MUL_HH: begin opa = signed'({1'b0, a_acc[33:17]}); opb = signed'({1'b0, b_acc[33:17]}); end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign roll_x  = signed'(33'(sq_w) + 33'(sq_z) - 33'(sq_x) - 33'(sq_y));
  assign yaw_x   = signed'(33'(sq_w) + 33'(sq_x) - 33'(sq_y) - 33'(sq_z));
  assign ab_diff = signed'(35'(b_acc) - 35'(a_acc));

  always_comb begin
    unique case (cmd.ang_sel)
      ANG_ROLL: begin
        src_x = MAG_W'(roll_x);
        src_y = MAG_W'(roll_n) <<< 1;
      end
      ANG_YAW: begin
        src_x = MAG_W'(yaw_x);
        src_y = MAG_W'(yaw_n) <<< 1;
      end
      ANG_PITCH: begin
        src_x = signed'(MAG_W'(root) << 1);
        src_y = MAG_W'(ab_diff) <<< k;
      end
      default: begin
        src_x = '0;
        src_y = '0;
      end
    endcase
    mag_x = src_x[MAG_W-1] ? MAG_W'(-src_x) : MAG_W'(src_x);
    mag_y = src_y[MAG_W-1] ? MAG_W'(-src_y) : MAG_W'(src_y);
  end

  assign m        = (ux > uy) ? ux : uy;
  assign dx       = cx >>> cmd.iter;
  assign dy       = cy >>> cmd.iter;
  assign z_step   = signed'(Z_W'(atan_lut(cmd.iter)));
  assign sq_trial = root + bitr;

  // first-quadrant angle, quadrant fold, rounding to output units
  always_comb begin
    if (uy_zero)                             af = '0;
    else if (ux_zero)                        af = ANG_W'(DEG90);
    else if (cz[Z_W-1])                      af = '0;
    else if (cz > signed'(Z_W'(DEG90)))      af = ANG_W'(DEG90);
    else                                     af = ANG_W'(cz);
    a_full   = neg_x ? ANG_W'(DEG180) - af : af;
    a_rnd    = (a_full + ANG_W'(HALF)) >> SH;
    a_signed = neg_y ? -signed'((ANG_W + 1)'(a_rnd)) : signed'((ANG_W + 1)'(a_rnd));
  end

  assign status.quat_zero    = quat_zero;
  assign status.ab_equal     = (a_acc == b_acc);
  assign status.p_zero       = (p_acc == '0);
  assign status.p_normed     = (p_acc[63:60] != '0);
  assign status.mag_zero     = ux_zero || uy_zero;
  assign status.mag_in_range = (m[MAG_W-1:30] == '0) && m[29];

  assign gap        = arrival_time_us - previous_time;
  assign missed_inc = sequence_number - previous_sequence - 8'd1;

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qx        <= 16'(quat_x >>> QRED);
      qy        <= 16'(quat_y >>> QRED);
      qz        <= 16'(quat_z >>> QRED);
      qw        <= 16'(quat_w >>> QRED);
      quat_zero <= (quat_x == '0) && (quat_y == '0) && (quat_z == '0) && (quat_w == '0);
      k         <= '0;
      root      <= '0;
      bitr      <= 64'(1) << 62;
    end

    prod     <= opa * opb;
    prod_op  <= cmd.mul_op;
    prod_vld <= cmd.mul_en;

    if (prod_vld) begin
      unique case (prod_op)
        MUL_A0: a_acc  <= 34'(prod);
        MUL_A1: a_acc  <= a_acc + 34'(prod);
        MUL_B0: b_acc  <= 34'(prod);
        MUL_B1: b_acc  <= b_acc + 34'(prod);
        MUL_WX: roll_n <= 34'(prod);
        MUL_YZ: roll_n <= roll_n + 34'(prod);
        MUL_WZ: yaw_n  <= 34'(prod);
        MUL_XY: yaw_n  <= yaw_n + 34'(prod);
        MUL_WW: sq_w   <= 31'(prod);
        MUL_XX: sq_x   <= 31'(prod);
        MUL_YY: sq_y   <= 31'(prod);
        MUL_ZZ: sq_z   <= 31'(prod);
        MUL_LL: p_acc  <= 64'(prod);
        MUL_LH: p_acc  <= p_acc + (64'(prod) << 17);
        MUL_HL: p_acc  <= p_acc + (64'(prod) << 17);
        MUL_HH: p_acc  <= p_acc + (64'(prod) << 34);
        default: ;
      endcase
    end

    if (cmd.p_norm_step) begin
      p_acc <= p_acc << 2;
      k     <= k + 5'd1;
    end

    if (cmd.sqrt_step) begin
      if (p_acc >= sq_trial) begin
        p_acc <= p_acc - sq_trial;
        root  <= (root >> 1) + bitr;
      end else begin
        root <= root >> 1;
      end
      bitr <= bitr >> 2;
    end

    if (cmd.ang_load) begin
      ux      <= mag_x;
      uy      <= mag_y;
      neg_x   <= src_x[MAG_W-1];
      neg_y   <= src_y[MAG_W-1];
      ux_zero <= (mag_x == '0);
      uy_zero <= (mag_y == '0);
    end else if (cmd.norm_step) begin
      if (m[MAG_W-1:30] != '0) begin
        ux <= ux >> 1;
        uy <= uy >> 1;
      end else begin
        ux <= ux << 1;
        uy <= uy << 1;
      end
    end

    if (cmd.cordic_init) begin
      cx <= signed'(CORD_W'(ux));
      cy <= signed'(CORD_W'(uy));
      cz <= '0;
    end else if (cmd.cordic_step) begin
      if (!cy[CORD_W-1]) begin
        cx <= cx + dy;
        cy <= cy - dx;
        cz <= cz + z_step;
      end else begin
        cx <= cx - dy;
        cy <= cy + dx;
        cz <= cz - z_step;
      end
    end

    if (cmd.out_load) begin
      roll_angle     <= last_roll;
      pitch_angle    <= last_pitch;
      yaw_angle      <= last_yaw;
      missed_reports <= missed_total;
      largest_gap_us <= max_gap;
      reports_seen   <= report_count;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_roll         <= '0;
      last_pitch        <= '0;
      last_yaw          <= '0;
      report_count      <= '0;
      previous_time     <= '0;
      previous_sequence <= '0;
      missed_total      <= '0;
      max_gap           <= '0;
    end else begin
      if (cmd.load) begin
        if (report_count != '0) begin
          if (gap > max_gap) max_gap <= gap;
          missed_total <= missed_total + 32'(missed_inc);
        end
        previous_time     <= arrival_time_us;
        previous_sequence <= sequence_number;
        report_count      <= report_count + 32'd1;
      end
      if (cmd.ang_write) begin
        unique case (cmd.ang_sel)
          ANG_ROLL:  last_roll  <= ROLL_W'(a_signed);
          ANG_YAW:   last_yaw   <= ROLL_W'(a_signed);
          ANG_PITCH: last_pitch <= PITCH_W'(a_signed);
          default: ;
        endcase
      end
      if (cmd.pitch_zero) last_pitch <= '0;
    end
  end

endmodule

/* rtl/quaternion_euler_stream_monitor_unit.sv */
// ---------------------------------------------------------------------------
// quaternion_euler_stream_monitor_unit
// Rotation-vector report to roll/pitch/yaw plus sequence-gap statistics.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one report per transfer: four
//   signed quaternion components, a sequence number and an arrival time.
//   Output channel (out_valid/out_stall) carries one result per report:
//   roll, pitch, yaw in 2^-ANGLE_FRAC_BITS degree and the running counters.
//   One report at a time: in_stall is high from the transfer until the
//   result has been moved into the output register.
//   An all-zero quaternion goes from the multiply state straight to the
//   done state. Otherwise 16 multiply steps and a drain state, then per
//   angle a load state, the normalising shifts, 23 CORDIC iterations and a
//   write state (an angle on an axis skips the shifts and the CORDIC), plus
//   up to 30 scaling steps and 32 root steps for pitch, run on the shared
//   CORDIC unit and the bit-serial square root.
//   After each result load the block returns to idle, so the next report
//   can be taken while that result is shown.
//   Reset clears the held angles and all counters; no result is pending.
//   A stalled result waits in its register; the next report may be taken
//   meanwhile and waits for that register before its own result is shown.
// ---------------------------------------------------------------------------
`include "quaternion_euler_stream_monitor_unit_macros.svh"

module quaternion_euler_stream_monitor_unit #(
  parameter  int QUAT_WIDTH      = qesm_pkg::QUAT_WIDTH_DEF,
  parameter  int ANGLE_FRAC_BITS = qesm_pkg::ANGLE_FRAC_BITS_DEF,
  localparam int ROLL_W          = qesm_pkg::angle_w(180, ANGLE_FRAC_BITS),
  localparam int PITCH_W         = qesm_pkg::angle_w(90, ANGLE_FRAC_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [QUAT_WIDTH-1:0] quat_x,
  input  logic signed [QUAT_WIDTH-1:0] quat_y,
  input  logic signed [QUAT_WIDTH-1:0] quat_z,
  input  logic signed [QUAT_WIDTH-1:0] quat_w,
  input  logic [7:0]                   sequence_number,
  input  logic [31:0]                  arrival_time_us,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [ROLL_W-1:0]     roll_angle,
  output logic signed [PITCH_W-1:0]    pitch_angle,
  output logic signed [ROLL_W-1:0]     yaw_angle,
  output logic [31:0]                  missed_reports,
  output logic [31:0]                  largest_gap_us,
  output logic [31:0]                  reports_seen
);
  import qesm_pkg::*;

  localparam int ROLL_MAX  = 180 << ANGLE_FRAC_BITS;
  localparam int PITCH_MAX = 90 << ANGLE_FRAC_BITS;

  cmd_t    cmd;
  status_t status;

  // sequencer: owns both handshakes
  qesm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic, held angles, statistics and output register
  qesm_datapath #(
    .QUAT_WIDTH      (QUAT_WIDTH),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .quat_x          (quat_x),
    .quat_y          (quat_y),
    .quat_z          (quat_z),
    .quat_w          (quat_w),
    .sequence_number (sequence_number),
    .arrival_time_us (arrival_time_us),
    .roll_angle      (roll_angle),
    .pitch_angle     (pitch_angle),
    .yaw_angle       (yaw_angle),
    .missed_reports  (missed_reports),
    .largest_gap_us  (largest_gap_us),
    .reports_seen    (reports_seen)
  );

  // a transfer in always leaves the block busy in the next cycle
  `QESM_ASSERT_NEXT(a_busy_after_xfer, clk, rst, in_valid && !in_stall, in_stall, "not busy after input transfer")
  // roll and pitch shown stay within their range
  `QESM_ASSERT_NOW(a_roll_range, clk, rst, out_valid, (roll_angle >= -ROLL_MAX) && (roll_angle <= ROLL_MAX), "roll out of range")
  `QESM_ASSERT_NOW(a_pitch_range, clk, rst, out_valid, (pitch_angle >= -PITCH_MAX) && (pitch_angle <= PITCH_MAX), "pitch out of range")

endmodule

/* tb/sv/quaternion_euler_stream_monitor_unit_test.sv */
// ---------------------------------------------------------------------------
// quaternion_euler_stream_monitor_unit_test
// Self-checking bench: drives reports through the input channel, predicts
// roll/pitch/yaw and the gap counters in-bench, and checks every result
// transfer field by field, in order, under random idling on both sides.
// ---------------------------------------------------------------------------
module quaternion_euler_stream_monitor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_SHIFT = 16 - qesm_pkg::ANGLE_FRAC_BITS_DEF;
  localparam longint DEG_90  = 90 * 65536;
  localparam longint DEG_180 = 180 * 65536;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // input channel
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] quat_x = '0;
  logic signed [15:0] quat_y = '0;
  logic signed [15:0] quat_z = '0;
  logic signed [15:0] quat_w = '0;
  logic [7:0]         sequence_number = '0;
  logic [31:0]        arrival_time_us = '0;

  // output channel
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic [31:0]        missed_reports;
  logic [31:0]        largest_gap_us;
  logic [31:0]        reports_seen;

  quaternion_euler_stream_monitor_unit dut (.*);

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic [31:0]        missed;
    logic [31:0]        gap;
    logic [31:0]        seen;
  } euler_result_t;

  euler_result_t pending_results[$];

  // predictor state, mirrors the block after reset
  logic signed [15:0] held_roll, held_yaw;
  logic signed [14:0] held_pitch;
  logic [31:0]        count_reports, prev_time, total_missed, widest_gap;
  logic [7:0]         prev_seq;

  int mismatches = 0;

  // idling controls
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold     = 0;

  // the sender's own view of the stream
  logic [7:0]  next_seq  = '0;
  logic [31:0] next_time = '0;

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // first-quadrant CORDIC vectoring, result in 2^-16 degree
  function automatic longint first_quadrant_angle(input longint unsigned ux,
                                                  input longint unsigned uy);
    longint unsigned m;
    longint cx, cy, acc, dx, dy;
    if (uy == 0) return 0;
    if (ux == 0) return DEG_90;
    m = (ux > uy) ? ux : uy;
    while (m >= (64'd1 << 30)) begin
      ux >>= 1; uy >>= 1; m >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      ux <<= 1; uy <<= 1; m <<= 1;
    end
    cx = longint'(ux);
    cy = longint'(uy);
    acc = 0;
    for (int i = 0; i < qesm_pkg::CORDIC_STEPS; i++) begin
      dx = cx >>> i;
      dy = cy >>> i;
      if (cy >= 0) begin
        cx += dy; cy -= dx; acc += longint'(qesm_pkg::atan_lut(i[4:0]));
      end else begin
        cx -= dy; cy += dx; acc -= longint'(qesm_pkg::atan_lut(i[4:0]));
      end
    end
    if (acc < 0) acc = 0;
    if (acc > DEG_90) acc = DEG_90;
    return acc;
  endfunction

  // full atan2 rounded to output units
  function automatic longint angle_from_xy(input longint y, input longint x);
    longint unsigned ux, uy;
    longint a;
    ux = (x < 0) ? longint'(-x) : x;
    uy = (y < 0) ? longint'(-y) : y;
    if (ux == 0 && uy == 0) return 0;
    a = first_quadrant_angle(ux, uy);
    if (x < 0) a = DEG_180 - a;
    a = (a + (64'sd1 << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    return (y < 0) ? -a : a;
  endfunction

  function automatic longint pitch_from_quat(input longint w, input longint x,
                                             input longint y, input longint z);
    longint unsigned a, b, p;
    longint diff;
    int k;
    a = (w - y) * (w - y) + (x + z) * (x + z);
    b = (w + y) * (w + y) + (x - z) * (x - z);
    diff = longint'(b) - longint'(a);
    if (a == b) return 0;
    p = a * b;
    if (p == 0) return angle_from_xy(diff, 0);
    k = 0;
    while (p < (64'd1 << 60)) begin
      p <<= 2;
      k++;
    end
    return angle_from_xy(diff * (64'sd1 << k), 2 * longint'(root64(p)));
  endfunction

  function automatic void reset_predictor();
    held_roll = '0; held_pitch = '0; held_yaw = '0;
    count_reports = '0; prev_time = '0; prev_seq = '0;
    total_missed = '0; widest_gap = '0;
  endfunction

  function automatic euler_result_t euler_predict(
      input logic signed [15:0] qx, input logic signed [15:0] qy,
      input logic signed [15:0] qz, input logic signed [15:0] qw,
      input logic [7:0] seq, input logic [31:0] stamp);
    euler_result_t r;
    longint x, y, z, w;
    logic [31:0] gap;
    logic [7:0]  skipped;
    x = qx; y = qy; z = qz; w = qw;
    // an all-zero quaternion holds the previous angles
    if (x != 0 || y != 0 || z != 0 || w != 0) begin
      held_roll  = 16'(angle_from_xy(2 * (w * x + y * z), w * w + z * z - x * x - y * y));
      held_yaw   = 16'(angle_from_xy(2 * (w * z + x * y), w * w + x * x - y * y - z * z));
      held_pitch = 15'(pitch_from_quat(w, x, y, z));
    end
    // first report (or after the counter wraps) only loads the history
    if (count_reports != 0) begin
      gap = stamp - prev_time;
      if (gap > widest_gap) widest_gap = gap;
      skipped = seq - prev_seq - 8'd1;
      total_missed += 32'(skipped);
    end
    prev_time = stamp;
    prev_seq = seq;
    count_reports++;
    r.roll = held_roll; r.pitch = held_pitch; r.yaw = held_yaw;
    r.missed = total_missed; r.gap = widest_gap; r.seen = count_reports;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one transfer per call. Valid stays high straight into the next
  // report unless a gap is drawn, so it is never dropped and raised in one step.
  // ---------------------------------------------------------------------------
  task automatic send_report(input logic signed [15:0] qx, input logic signed [15:0] qy,
                             input logic signed [15:0] qz, input logic signed [15:0] qw,
                             input logic [7:0] seq, input logic [31:0] stamp);
    int gap;
    gap = 0;
    if (send_idle_pct > 0)
      while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    quat_x <= qx; quat_y <= qy; quat_z <= qz; quat_w <= qw;
    sequence_number <= seq;
    arrival_time_us <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer taken at this edge
    pending_results.push_back(euler_predict(qx, qy, qz, qw, seq, stamp));
  endtask

  // stream-shaped report: mostly in sequence, sometimes skips or repeats
  task automatic send_stream_report(input logic signed [15:0] qx,
                                    input logic signed [15:0] qy,
                                    input logic signed [15:0] qz,
                                    input logic signed [15:0] qw);
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) next_seq++;
    else if (pick < 90) next_seq += 8'($urandom_range(255));
    else if (pick < 95) next_seq = next_seq;  // duplicate
    else next_seq = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 70) next_time += 32'($urandom_range(20000, 1));
    else if (pick < 90) next_time += 32'($urandom_range(2000000));
    else next_time = $urandom;
    send_report(qx, qy, qz, qw, next_seq, next_time);
  endtask

  // drop valid at the edge of the last transfer so no stale report is offered
  task automatic idle_inputs();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall, plus a counted hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  // result checker: every transfer against the oldest expectation
  always @(posedge clk) begin
    euler_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, reports_seen", reports_seen, -1);
      end else begin
        want = pending_results.pop_front();
        if (roll_angle !== want.roll) report_mismatch("roll_angle", roll_angle, want.roll);
        if (pitch_angle !== want.pitch)
          report_mismatch("pitch_angle", pitch_angle, want.pitch);
        if (yaw_angle !== want.yaw) report_mismatch("yaw_angle", yaw_angle, want.yaw);
        if (missed_reports !== want.missed)
          report_mismatch("missed_reports", missed_reports, want.missed);
        if (largest_gap_us !== want.gap)
          report_mismatch("largest_gap_us", largest_gap_us, want.gap);
        if (reports_seen !== want.seen)
          report_mismatch("reports_seen", reports_seen, want.seen);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // fixed corner cases: first report, zero quaternion, axes, gimbal lock,
  // field extremes, duplicate and wrapping sequence numbers, time wrap
  task automatic test_directed();
    send_report(16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd5, 32'd1000);           // first, zero
    send_report(16'sd0, 16'sd0, 16'sd0, 16'sd16384, 8'd6, 32'd2000);       // identity
    send_report(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 8'd7, 32'd3000);       // roll 180
    send_report(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 8'd8, 32'd4000);       // yaw 180
    send_report(16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 8'd9, 32'd5000);   // pitch +90
    send_report(16'sd0, -16'sd16384, 16'sd0, 16'sd16384, 8'd10, 32'd6000); // pitch -90
    send_report(16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd11, 32'd7000);          // hold angles
    send_report(16'sd11585, 16'sd11585, 16'sd11585, 16'sd11585, 8'd12, 32'd8000);
    send_report(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 8'd12, 32'd9000);
    send_report(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 8'd255, 32'hFFFF_FF00);
    send_report(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 8'd0, 32'h0000_0100);
    send_report(16'sd1, 16'sd0, 16'sd0, 16'sd0, 8'd1, 32'h0000_0100);
    send_report(16'sd0, 16'sd0, 16'sd0, -16'sd1, 8'd3, 32'hFFFF_FFFF);
    send_report(16'sd0, 16'sd0, -16'sd16384, 16'sd0, 8'd4, 32'd0);
    send_report(-16'sd16384, 16'sd0, 16'sd0, 16'sd1, 8'd5, 32'd10);
    send_report(16'sd0, -16'sd1, 16'sd0, 16'sd0, 8'd6, 32'd20);
    send_report(16'sd1, 16'sd1, 16'sd1, 16'sd1, 8'd7, 32'd30);
    send_report(16'sd32767, -16'sd32768, 16'sd1, -16'sd1, 8'd8, 32'd40);
    next_seq = 8'd8;
    next_time = 32'd40;
  endtask

  // random quaternion: mostly full range, some small, some zero or near-axis
  task automatic send_random_report();
    int pick;
    logic signed [15:0] c[4];
    pick = $urandom_range(99);
    foreach (c[i]) begin
      if (pick < 60) c[i] = 16'($urandom);
      else if (pick < 80) c[i] = 16'(int'($urandom_range(64)) - 32);
      else if (pick < 85) c[i] = '0;
      else c[i] = ($urandom_range(1)) ? 16'($urandom) : 16'sd0;
    end
    send_stream_report(c[0], c[1], c[2], c[3]);
  endtask

  task automatic test_random_idling();
    send_idle_pct = 10; recv_idle_pct = 74;
    repeat (300) send_random_report();
    send_idle_pct = 74; recv_idle_pct = 10;
    repeat (300) send_random_report();
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (300) send_random_report();
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_back_pressure();
    send_idle_pct = 0; recv_idle_pct = 0;
    recv_hold = 3000;
    repeat (8) send_random_report();
    // sender pauses until every result is back
    idle_inputs();
    wait_drained();
    repeat (20) send_random_report();
  endtask

  initial begin
    reset_predictor();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_back_pressure();
    test_random_idling();
    idle_inputs();
    send_idle_pct = 0; recv_idle_pct = 0;
    wait_drained();
    repeat (400) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("quaternion_euler_stream_monitor_unit test passed");
    end else begin
      $display("quaternion_euler_stream_monitor_unit test failed");
    end
    $finish;
  end

  // overall limit, several times the slowest legal run
  initial begin
    #20ms;
    $display("quaternion_euler_stream_monitor_unit test failed");
    $finish;
  end

endmodule
